[rtl/wbe_pkg.sv]
package wbe_pkg;

    localparam int DEF_MAX_WINDOW    = 4096;
    localparam int DEF_LOG_FRAC_BITS = 16;

    localparam int WS_W      = 13;      // window_size and window_bytes width
    localparam int BYTE_W    = 8;
    localparam int NBINS     = 256;
    localparam int ENT_W     = 17;      // entropy_norm width
    localparam int ENT_SHIFT = 13;      // scale 2^13 folds the divide by 8 into 65536 = 1.0
    localparam int ENT_ONE   = 65536;
    localparam int WS_RESET  = 256;
    localparam int MANT_W    = 32;      // Q30 mantissa register, values below 2^31
    localparam int MANT_FRAC = 30;

    typedef struct packed {
        logic take_in;    // latch request, read its bin
        logic bump;       // write bin + 1, advance byte count
        logic clr_step;   // clear one bin during the sweep after reset
        logic walk_rd;    // read and clear one bin of the walk
        logic walk_next;  // advance walk address
        logic log_bin;    // start log2 of bin count
        logic log_tot;    // start log2 of window length
        logic acc_mul;    // product of bin count and its log
        logic acc_add;    // add product into sum
        logic tot_mul;    // product of window length and its log
        logic div_start;
        logic load_out;   // load result register, reset window
    } wbe_cmd_t;

    typedef struct packed {
        logic close_win;
        logic addr_last;
        logic bin_zero;
        logic log_done;
        logic div_done;
        logic out_free;
    } wbe_sts_t;

endpackage

[rtl/windowed_byte_entropy.sv]
// Per byte: accept with bin read, then bin increment, then window check.
// Window close: every bin is read and cleared; for an occupied bin the log2 of its
// count is taken and count * log is accumulated. Then the log2 of the window length,
// a shift-and-subtract divide of the 47-bit numerator (default parameters), result load.
// One request in flight at a time; input is accepted while a result waits.
// Reset (async, active low) starts a clearing pass over all 256 bins; no request taken.
module windowed_byte_entropy #(
    parameter int MAX_WINDOW    = wbe_pkg::DEF_MAX_WINDOW,
    parameter int LOG_FRAC_BITS = wbe_pkg::DEF_LOG_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [16:0] entropy_norm, [29:17] window_bytes
    output logic        m_axis_tlast,   // is_final
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data        // window_size
);
    import wbe_pkg::*;

    wbe_cmd_t         cmd;
    wbe_sts_t         sts;
    logic [ENT_W-1:0] entropy;
    logic [WS_W-1:0]  wbytes;

    assign cfg_ready = 1'b1;

    wbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wbe_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_wdata   (cfg_data),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_entropy (entropy),
        .out_bytes   (wbytes),
        .out_final   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, wbytes, entropy};

endmodule

[rtl/wbe_log2.sv]
module wbe_log2 #(
    parameter int CW = 13,
    parameter int F  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [CW-1:0]                  x,
    output logic                           done,
    output logic [$clog2(CW)+F-1:0]        result
);
    import wbe_pkg::*;

    localparam int KW = $clog2(CW);
    localparam int LW = KW + F;
    localparam int IW = $clog2(F);

    logic [KW-1:0]     k;
    logic [MANT_W-1:0] y_reg, y_next;
    logic [LW-1:0]     r_reg;
    logic [IW-1:0]     iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;

    always_comb
    begin
        k = '0;
        for (int i = 1; i < CW; i++)
        begin
            if (x[i])
            begin
                k = KW'(i);
            end
        end
    end

    assign sq = y_reg * y_reg;
    assign t  = sq[MANT_FRAC+MANT_W:MANT_FRAC];

    // renormalize when the square reaches 2.0
    assign y_next = (t[MANT_W:MANT_W-1] != 2'b00) ? t[MANT_W:1] : t[MANT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            y_reg    <= '0;
            r_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= IW'(F - 1);
                y_reg    <= MANT_W'(x) << (MANT_FRAC - int'(k));
                r_reg    <= LW'(k) << F;
            end
            else if (busy_reg)
            begin
                y_reg <= y_next;
                if (t[MANT_W:MANT_W-1] != 2'b00)
                begin
                    r_reg <= r_reg | (LW'(1) << iter_reg);
                end
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[rtl/wbe_div.sv]
module wbe_div #(
    parameter int NW = 48,
    parameter int DW = 29
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  num_reg, q_reg;
    logic [DW-1:0]  den_reg, rem_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic [DW:0]    rem_sh;
    logic           ge;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[NW-2:0], ge};
                rem_reg <= ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
                if (cnt_reg == CNW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/wbe_datapath.sv]
module wbe_datapath #(
    parameter int MAX_WINDOW    = 4096,
    parameter int LOG_FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wbe_pkg::wbe_cmd_t      cmd,
    output wbe_pkg::wbe_sts_t      sts,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    input  logic                   cfg_we,
    input  logic [12:0]            cfg_wdata,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [16:0]            out_entropy,
    output logic [12:0]            out_bytes,
    output logic                   out_final
);
    import wbe_pkg::*;

    localparam int F  = LOG_FRAC_BITS;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int KW = $clog2(CW);
    localparam int LW = KW + F;
    localparam int PW = CW + LW;
    localparam int DW = CW + F;
    localparam int NW = PW + ENT_SHIFT + 1;

    logic [CW-1:0]     mem [NBINS];
    logic [CW-1:0]     rd_data_reg;
    logic              rd_en, wr_en;
    logic [BYTE_W-1:0] rd_addr, wr_addr;
    logic [CW-1:0]     wr_data;

    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] addr_reg;
    logic [CW-1:0]     bytes_reg;
    logic [WS_W-1:0]   ws_reg;
    logic [PW-1:0]     prod_reg, sum_reg;
    logic              out_valid_reg, fin_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [WS_W-1:0]   wb_reg;

    logic [31:0]       limit;
    logic [CW-1:0]     log_x;
    logic              log_done;
    logic [LW-1:0]     log_r;
    logic [CW-1:0]     mul_a;
    logic [PW-1:0]     diff;
    logic [NW-1:0]     num;
    logic [DW-1:0]     den;
    logic              div_done;
    logic [NW-1:0]     quot;

    // one read and one write port
    always_comb
    begin
        rd_en   = cmd.take_in | cmd.walk_rd;
        rd_addr = cmd.take_in ? in_byte : addr_reg;
        wr_en   = cmd.bump | cmd.clr_step | cmd.walk_rd;
        wr_addr = cmd.bump ? byte_reg : addr_reg;
        wr_data = cmd.bump ? CW'(rd_data_reg + 1'b1) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        if (ws_reg == '0)
        begin
            limit = 32'd1;
        end
        else if (32'(ws_reg) > 32'(MAX_WINDOW))
        begin
            limit = 32'(MAX_WINDOW);
        end
        else
        begin
            limit = 32'(ws_reg);
        end
    end

    assign log_x = cmd.log_tot ? bytes_reg : rd_data_reg;
    assign mul_a = cmd.tot_mul ? bytes_reg : rd_data_reg;
    assign diff  = (prod_reg > sum_reg) ? PW'(prod_reg - sum_reg) : '0;
    assign num   = (NW'(diff) << ENT_SHIFT) + (NW'(bytes_reg) << (F - 1));
    assign den   = DW'(bytes_reg) << F;

    wbe_log2 #(
        .CW (CW),
        .F  (F)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_bin | cmd.log_tot),
        .x      (log_x),
        .done   (log_done),
        .result (log_r)
    );

    wbe_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            addr_reg      <= '0;
            bytes_reg     <= '0;
            ws_reg        <= WS_W'(WS_RESET);
            prod_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            ent_reg       <= '0;
            wb_reg        <= '0;
            fin_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ws_reg <= cfg_wdata;
            end
            if (cmd.take_in)
            begin
                byte_reg <= in_byte;
                last_reg <= in_last;
            end
            if (cmd.bump)
            begin
                bytes_reg <= bytes_reg + 1'b1;
            end
            if (cmd.clr_step || cmd.walk_next)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.acc_mul || cmd.tot_mul)
            begin
                prod_reg <= PW'(mul_a) * PW'(log_r);
            end
            if (cmd.acc_add)
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                ent_reg       <= (quot > NW'(ENT_ONE)) ? ENT_W'(ENT_ONE) : quot[ENT_W-1:0];
                wb_reg        <= WS_W'(bytes_reg);
                fin_reg       <= last_reg;
                bytes_reg     <= '0;
                sum_reg       <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.close_win = (32'(bytes_reg) >= limit) || last_reg;
        sts.addr_last = addr_reg == BYTE_W'(NBINS - 1);
        sts.bin_zero  = rd_data_reg == '0;
        sts.log_done  = log_done;
        sts.div_done  = div_done;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_entropy = ent_reg;
    assign out_bytes   = wb_reg;
    assign out_final   = fin_reg;

`ifndef SYNTH
    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bytes_reg) <= 32'(MAX_WINDOW))
        else $error("window byte count above maximum");
    a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> 32'(ent_reg) <= 32'(ENT_ONE))
        else $error("entropy above 1.0");
`endif

endmodule

[rtl/wbe_ctrl.sv]
module wbe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wbe_pkg::wbe_sts_t sts,
    output wbe_pkg::wbe_cmd_t cmd
);
    import wbe_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_INC  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_WRD  = 4'd4;
    localparam logic [3:0] S_WCHK = 4'd5;
    localparam logic [3:0] S_WLOG = 4'd6;
    localparam logic [3:0] S_WMUL = 4'd7;
    localparam logic [3:0] S_WADD = 4'd8;
    localparam logic [3:0] S_TOT  = 4'd9;
    localparam logic [3:0] S_TLOG = 4'd10;
    localparam logic [3:0] S_TMUL = 4'd11;
    localparam logic [3:0] S_DIVS = 4'd12;
    localparam logic [3:0] S_DIVW = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_INC;
                end
            end
            S_INC:
            begin
                cmd.bump   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = sts.close_win ? S_WRD : S_IDLE;
            end
            S_WRD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WCHK;
            end
            S_WCHK:
            begin
                // skip empty bins
                if (sts.bin_zero)
                begin
                    cmd.walk_next = 1'b1;
                    state_next    = sts.addr_last ? S_TOT : S_WRD;
                end
                else
                begin
                    cmd.log_bin = 1'b1;
                    state_next  = S_WLOG;
                end
            end
            S_WLOG:
            begin
                if (sts.log_done)
                begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                cmd.acc_mul = 1'b1;
                state_next  = S_WADD;
            end
            S_WADD:
            begin
                cmd.acc_add   = 1'b1;
                cmd.walk_next = 1'b1;
                state_next    = sts.addr_last ? S_TOT : S_WRD;
            end
            S_TOT:
            begin
                cmd.log_tot = 1'b1;
                state_next  = S_TLOG;
            end
            S_TLOG:
            begin
                if (sts.log_done)
                begin
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                cmd.tot_mul = 1'b1;
                state_next  = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a waiting result");
    a_inc_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_in |=> cmd.bump)
        else $error("bin increment did not follow request");
`endif

endmodule
